/* src/mte_pkg.sv */
package mte_pkg;

	// opcodes of an input transaction
	localparam logic [1:0] OP_CHAR  = 2'd0;
	localparam logic [1:0] OP_SEP   = 2'd1;
	localparam logic [1:0] OP_CLOSE = 2'd2;

	// timing unit kinds
	localparam logic [1:0] UNIT_OFF = 2'd0;
	localparam logic [1:0] UNIT_ON  = 2'd1;
	localparam logic [1:0] UNIT_END = 2'd2;

	// character codes
	localparam logic [7:0] CHAR_SPACE  = 8'h20;
	localparam logic [7:0] CHAR_PERIOD = 8'h2E;
	localparam logic [7:0] CHAR_A      = 8'h61;
	localparam logic [7:0] CHAR_Z      = 8'h7A;

	// run lengths
	localparam int RUN_W = 3;
	localparam logic [RUN_W-1:0] WORD_GAP   = 3'd7;
	localparam logic [RUN_W-1:0] LETTER_GAP = 3'd3;
	localparam logic [RUN_W-1:0] DASH_LEN   = 3'd3;
	localparam logic [RUN_W-1:0] DOT_LEN    = 3'd1;

	// cap on units per transaction
	localparam int MAX_UNITS  = 16;
	localparam int UNIT_CNT_W = $clog2(MAX_UNITS);

	localparam int LETTERS = 26;
	localparam int ROM_IDX_W = $clog2(LETTERS);

	// bits 6..4 symbol count, bit i of 3..0 is symbol i (1 dash, 0 dot)
	localparam logic [6:0] PATTERN_ROM [LETTERS] = '{
		7'h22, 7'h41, 7'h45, 7'h31, 7'h10, 7'h44, 7'h33, 7'h40, 7'h20, 7'h4E,
		7'h35, 7'h42, 7'h23, 7'h21, 7'h37, 7'h46, 7'h4B, 7'h32, 7'h30, 7'h11,
		7'h34, 7'h48, 7'h36, 7'h49, 7'h4D, 7'h43
	};

	// control of the shared run-length counter
	typedef struct packed {
		logic             load;
		logic             dec;
		logic [RUN_W-1:0] value;
	} cnt_ctrl_t;

endpackage

/* src/mte_if.sv */
interface mte_text_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] char_code;
	logic       last_of_arg;

	modport source (output valid, output opcode, output char_code, output last_of_arg,
		input ready);
	modport sink (input valid, input opcode, input char_code, input last_of_arg,
		output ready);
endinterface

interface mte_unit_if;
	logic       valid;
	logic       ready;
	logic [1:0] unit_kind;
	logic       last;

	modport source (output valid, output unit_kind, output last, input ready);
	modport sink (input valid, input unit_kind, input last, output ready);
endinterface

/* src/mte_run_cnt.sv */
module mte_run_cnt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mte_pkg::cnt_ctrl_t            ctrl,
	output logic [mte_pkg::RUN_W-1:0]     count,
	output logic                          at_one
);

	logic [mte_pkg::RUN_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.load) begin
			count_q <= ctrl.value;
		end else if (ctrl.dec && count_q != '0) begin
			count_q <= count_q - 1'b1;
		end
	end

	assign count  = count_q;
	assign at_one = (count_q == mte_pkg::RUN_W'(1));

endmodule

/* src/morse_text_encoder_unit.sv */
// Channel   Dir  Handshake     Payload
// text      in   valid/ready   opcode[1:0], char_code[7:0], last_of_arg
// units     out  valid/ready   unit_kind[1:0], last
//
// One timing unit leaves per cycle while the output register is free; a
// transaction carries at most 16 units, the cap set by MAX_UNITS.
// The shared run-length counter paces every on run and off gap in turn.
// text.ready is high only while the sequencer is idle.
// Reset (arst_n low) clears the sequencer, the end and mute flags and the
// output valid bit. A stall on units holds the sequencer in place.
module morse_text_encoder_unit (
	input  logic            clk,
	input  logic            arst_n,
	mte_text_if.sink        text,
	mte_unit_if.source      units
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_ON   = 5'b00010,
		ST_SEP  = 5'b00100,
		ST_GAP  = 5'b01000,
		ST_ENDM = 5'b10000
	} state_t;

	state_t                           state_q, state_d;
	logic [2:0]                       sym_rem_q;
	logic [3:0]                       pat_q;
	logic [mte_pkg::RUN_W-1:0]        gap_q;
	logic                             end_q;
	logic                             ended_q, skip_q;
	logic [mte_pkg::UNIT_CNT_W-1:0]   ucnt_q;
	logic                             out_valid_q, out_last_q;
	logic [1:0]                       out_kind_q;

	// decode of the incoming transaction
	logic                             accept;
	logic                             is_letter;
	logic [7:0]                       char_off;
	logic [mte_pkg::ROM_IDX_W-1:0]    rom_idx;
	logic [6:0]                       rom_word;
	logic [2:0]                       p_len;
	logic [3:0]                       p_pat;
	logic [mte_pkg::RUN_W-1:0]        p_gap;
	logic                             p_end;
	logic                             ended_d, skip_d;

	// emission
	logic                             fire;
	logic                             more_sym;
	logic                             nat_last, unit_last;
	logic [1:0]                       unit_kind;

	mte_pkg::cnt_ctrl_t               cnt_ctrl;
	logic [mte_pkg::RUN_W-1:0]        run_cnt;
	logic                             run_at_one;

	mte_run_cnt u_run_cnt (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (cnt_ctrl),
		.count  (run_cnt),
		.at_one (run_at_one)
	);

	assign text.ready = (state_q == ST_IDLE);
	assign accept     = text.valid && text.ready;

	// Look up the letter pattern; non-letters read entry zero and are ignored.
	assign char_off  = text.char_code - mte_pkg::CHAR_A;
	assign is_letter = (text.char_code >= mte_pkg::CHAR_A) &&
		(text.char_code <= mte_pkg::CHAR_Z);
	assign rom_idx   = is_letter ? char_off[mte_pkg::ROM_IDX_W-1:0] : '0;
	assign rom_word  = mte_pkg::PATTERN_ROM[rom_idx];

	// Plan the transaction: symbols, then an off gap, then an end mark.
	always_comb begin
		p_len   = '0;
		p_pat   = '0;
		p_gap   = '0;
		p_end   = 1'b0;
		ended_d = ended_q;
		skip_d  = skip_q;
		case (text.opcode)
			mte_pkg::OP_CHAR: begin
				if (!skip_q) begin
					if (text.char_code == mte_pkg::CHAR_SPACE) begin
						p_gap = mte_pkg::WORD_GAP;
					end else if (text.char_code == mte_pkg::CHAR_PERIOD) begin
						// send the end mark only once, then mute the argument
						p_end   = !ended_q;
						ended_d = 1'b1;
						skip_d  = 1'b1;
					end else begin
						if (is_letter) begin
							p_len = rom_word[6:4];
							p_pat = rom_word[3:0];
						end
						if (!text.last_of_arg) begin
							p_gap = mte_pkg::LETTER_GAP;
						end
					end
				end
			end
			mte_pkg::OP_SEP: begin
				skip_d = 1'b0;
				p_gap  = mte_pkg::WORD_GAP;
			end
			mte_pkg::OP_CLOSE: begin
				skip_d = 1'b0;
				if (!ended_q) begin
					p_gap   = mte_pkg::WORD_GAP;
					p_end   = 1'b1;
					ended_d = 1'b1;
				end
			end
			default: begin
				// unused opcode: drop it with no effect
			end
		endcase
	end

	// While busy, emit a unit whenever the output register is free or being drained.
	assign fire     = (state_q != ST_IDLE) && (!out_valid_q || units.ready);
	assign more_sym = (sym_rem_q > 3'd1);

	always_comb begin
		unit_kind = mte_pkg::UNIT_OFF;
		nat_last  = 1'b0;
		unique case (state_q)
			ST_ON: begin
				unit_kind = mte_pkg::UNIT_ON;
				nat_last  = run_at_one && !more_sym && (gap_q == '0) && !end_q;
			end
			ST_SEP: begin
				nat_last = 1'b0;
			end
			ST_GAP: begin
				nat_last = run_at_one && !end_q;
			end
			ST_ENDM: begin
				unit_kind = mte_pkg::UNIT_END;
				nat_last  = 1'b1;
			end
			default: begin
				nat_last = 1'b0;
			end
		endcase
	end

	// Close the transaction early if the unit cap is reached.
	assign unit_last = nat_last ||
		(ucnt_q == mte_pkg::UNIT_CNT_W'(mte_pkg::MAX_UNITS - 1));

	// Sequencer: pick the next phase and drive the shared counter.
	always_comb begin
		state_d        = state_q;
		cnt_ctrl.load  = 1'b0;
		cnt_ctrl.dec   = 1'b0;
		cnt_ctrl.value = '0;
		if (accept) begin
			if (p_len != '0) begin
				state_d        = ST_ON;
				cnt_ctrl.load  = 1'b1;
				cnt_ctrl.value = p_pat[0] ? mte_pkg::DASH_LEN : mte_pkg::DOT_LEN;
			end else if (p_gap != '0) begin
				state_d        = ST_GAP;
				cnt_ctrl.load  = 1'b1;
				cnt_ctrl.value = p_gap;
			end else if (p_end) begin
				state_d = ST_ENDM;
			end
		end else if (fire) begin
			if (unit_last) begin
				state_d = ST_IDLE;
			end else begin
				unique case (state_q)
					ST_ON: begin
						if (!run_at_one) begin
							cnt_ctrl.dec = 1'b1;
						end else if (more_sym) begin
							state_d = ST_SEP;
						end else if (gap_q != '0) begin
							state_d        = ST_GAP;
							cnt_ctrl.load  = 1'b1;
							cnt_ctrl.value = gap_q;
						end else begin
							state_d = ST_ENDM;
						end
					end
					ST_SEP: begin
						// pattern already shifted to the next symbol
						state_d        = ST_ON;
						cnt_ctrl.load  = 1'b1;
						cnt_ctrl.value = pat_q[0] ? mte_pkg::DASH_LEN : mte_pkg::DOT_LEN;
					end
					ST_GAP: begin
						if (!run_at_one) begin
							cnt_ctrl.dec = 1'b1;
						end else begin
							state_d = ST_ENDM;
						end
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			sym_rem_q <= '0;
			pat_q     <= '0;
			gap_q     <= '0;
			end_q     <= 1'b0;
			ended_q   <= 1'b0;
			skip_q    <= 1'b0;
			ucnt_q    <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				sym_rem_q <= p_len;
				pat_q     <= p_pat;
				gap_q     <= p_gap;
				end_q     <= p_end;
				ended_q   <= ended_d;
				skip_q    <= skip_d;
				ucnt_q    <= '0;
			end else if (fire) begin
				ucnt_q <= ucnt_q + 1'b1;
				// advance to the next symbol at the end of an on run
				if (state_q == ST_ON && run_at_one && more_sym) begin
					sym_rem_q <= sym_rem_q - 3'd1;
					pat_q     <= {1'b0, pat_q[3:1]};
				end
			end
		end
	end

	// Output register: hold the unit until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (units.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_kind_q <= unit_kind;
			out_last_q <= unit_last;
		end
	end

	assign units.valid     = out_valid_q;
	assign units.unit_kind = out_kind_q;
	assign units.last      = out_last_q;

`ifndef SYNTH
	a_close_sets_ended: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && text.opcode == mte_pkg::OP_CLOSE) |=> ended_q)
		else $error("close transaction did not set the ended flag");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(units.valid && units.unit_kind == mte_pkg::UNIT_END) |-> units.last)
		else $error("end mark not flagged as last unit");

	a_on_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (state_q == ST_ON || state_q == ST_GAP)) |-> (run_cnt != '0))
		else $error("run counter empty while emitting a run");

	a_busy_blocks_text: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !unit_last) |=> !text.ready)
		else $error("input accepted before transaction finished");
`endif

endmodule

/* bench/morse_unit_checker.sv */
module morse_unit_checker
	import mte_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	mte_text_if  text,
	mte_unit_if  units,
	output int   fails,
	output int   units_waiting,
	output int   units_checked
);

	typedef struct packed {
		logic [1:0] kind;
		logic       last;
	} unit_t;

	unit_t expected_units[$];
	unit_t burst[$];
	logic  end_sent = 1'b0;
	logic  muted = 1'b0;
	int    fail_cnt = 0;
	int    checked_cnt = 0;

	function automatic void add_run(input logic [1:0] kind, input int count);
		unit_t u;
		u.kind = kind;
		u.last = 1'b0;
		for (int k = 0; k < count; k++) begin
			if (burst.size() < MAX_UNITS)
				burst.push_back(u);
		end
	endfunction

	// dots and dashes from the pattern table, one off unit between symbols
	function automatic void encode_letter(input int idx);
		logic [6:0] code;
		int         len;
		code = PATTERN_ROM[idx];
		len = int'(code[6:4]);
		for (int s = 0; s < len && s < 4; s++) begin
			add_run(UNIT_ON, code[s] ? int'(DASH_LEN) : int'(DOT_LEN));
			if (s + 1 < len)
				add_run(UNIT_OFF, 1);
		end
	endfunction

	function automatic void encode_text_item(input logic [1:0] op, input logic [7:0] ch,
			input logic last_arg);
		unit_t u;
		burst.delete();
		case (op)
			OP_CHAR: begin
				if (!muted) begin
					if (ch == CHAR_SPACE) begin
						add_run(UNIT_OFF, int'(WORD_GAP));
					end else if (ch == CHAR_PERIOD) begin
						if (!end_sent)
							add_run(UNIT_END, 1);
						end_sent = 1'b1;
						muted = 1'b1;
					end else begin
						if (ch >= CHAR_A && ch <= CHAR_Z)
							encode_letter(int'(ch - CHAR_A));
						if (!last_arg)
							add_run(UNIT_OFF, int'(LETTER_GAP));
					end
				end
			end
			OP_SEP: begin
				muted = 1'b0;
				add_run(UNIT_OFF, int'(WORD_GAP));
			end
			OP_CLOSE: begin
				muted = 1'b0;
				if (!end_sent) begin
					add_run(UNIT_OFF, int'(WORD_GAP));
					add_run(UNIT_END, 1);
					end_sent = 1'b1;
				end
			end
			default: begin
			end
		endcase
		// flag the final unit of the burst
		for (int i = 0; i < burst.size(); i++) begin
			u = burst[i];
			u.last = (i == burst.size() - 1);
			expected_units.push_back(u);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		unit_t want;
		if (!arst_n) begin
			end_sent = 1'b0;
			muted = 1'b0;
			expected_units.delete();
		end else begin
			if (text.valid && text.ready)
				encode_text_item(text.opcode, text.char_code, text.last_of_arg);
			if (units.valid && units.ready) begin
				checked_cnt++;
				if (expected_units.size() == 0) begin
					fail_cnt++;
					$display("%0t: unit with nothing expected: got kind %0d last %0b",
						$time, units.unit_kind, units.last);
				end else begin
					want = expected_units.pop_front();
					if (units.unit_kind !== want.kind || units.last !== want.last) begin
						fail_cnt++;
						$display("%0t: unit mismatch: expected kind %0d last %0b, got kind %0d last %0b",
							$time, want.kind, want.last, units.unit_kind, units.last);
					end
				end
			end
		end
		fails <= fail_cnt;
		units_waiting <= expected_units.size();
		units_checked <= checked_cnt;
	end

endmodule

/* bench/tb_top.sv */
module tb_top;
	import mte_pkg::*;

	// opcode that the encoder must ignore
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam int ITEM_TARGET    = 410;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 40;

	logic clk;
	logic arst_n;

	mte_text_if text ();
	mte_unit_if units ();

	int   fails;
	int   units_waiting;
	int   units_checked;
	int   items_sent = 0;
	int   tx_idle_pct = 13;
	int   rx_idle_pct = 88;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	logic first_end_by_close;

	morse_text_encoder_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.units  (units)
	);

	morse_unit_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.text          (text),
		.units         (units),
		.fails         (fails),
		.units_waiting (units_waiting),
		.units_checked (units_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one text transaction, idling first at the current rate. Keep valid
	// high when no idle cycle comes between two transactions.
	task automatic send_text(input logic [1:0] op, input logic [7:0] ch, input logic last_arg);
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			text.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < tx_idle_pct);
		end
		text.valid <= 1'b1;
		text.opcode <= op;
		text.char_code <= ch;
		text.last_of_arg <= last_arg;
		do
			@(posedge clk);
		while (!text.ready);
		if (op != OP_UNUSED)
			items_sent++;
	endtask

	// Mostly well-formed messages: arguments of letters ending on last_of_arg,
	// separators between them, the odd space or period, and a close. The rest
	// is raw noise over every opcode and byte.
	task automatic fill_random(input int upto);
		int         nargs;
		int         nchars;
		int         pick;
		int         a;
		int         c;
		logic [7:0] ch;
		while (items_sent < upto) begin
			if ($urandom_range(0, 9) < 8) begin
				nargs = $urandom_range(1, 3);
				for (a = 0; a < nargs; a++) begin
					if (a > 0)
						send_text(OP_SEP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
					nchars = $urandom_range(1, 6);
					for (c = 0; c < nchars; c++) begin
						pick = $urandom_range(0, 99);
						if (pick < 84)
							ch = CHAR_A + 8'($urandom_range(0, 25));
						else if (pick < 90)
							ch = CHAR_SPACE;
						else if (pick < 93)
							ch = CHAR_PERIOD;
						else
							ch = 8'($urandom_range(0, 255));
						send_text(OP_CHAR, ch, c == nchars - 1);
					end
				end
				if ($urandom_range(0, 1))
					send_text(OP_CLOSE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end else begin
				send_text(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
			end
		end
	endtask

	// Receiver: stall at random at the current rate. Once asked, hold ready
	// low for a long stretch so the encoder fills and backs up the text side.
	initial begin
		units.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				units.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end
			units.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// Watchdog: end the run when no transaction moves on either side for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((text.valid && text.ready) || (units.valid && units.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no transaction for %0d cycles, giving up", $time, WATCHDOG_LIMIT);
		$display("FAILURE");
		$finish;
	end

	initial begin
		text.valid <= 1'b0;
		text.opcode <= OP_CHAR;
		text.char_code <= 8'h00;
		text.last_of_arg <= 1'b0;
		arst_n <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: letter extremes, the longest bursts, bytes just outside
		// a-z, spaces, separator and the ignored opcode.
		send_text(OP_CHAR, 8'h65, 1'b0);          // 'e': single dot
		send_text(OP_CHAR, CHAR_A, 1'b0);
		send_text(OP_CHAR, CHAR_Z, 1'b1);
		send_text(OP_CHAR, 8'h6A, 1'b0);          // 'j': sixteen units with gap
		send_text(OP_CHAR, 8'h71, 1'b1);          // 'q'
		send_text(OP_CHAR, 8'h00, 1'b0);          // nothing sent, gap only
		send_text(OP_CHAR, 8'hFF, 1'b1);          // nothing at all
		send_text(OP_CHAR, CHAR_A - 8'd1, 1'b0);
		send_text(OP_CHAR, CHAR_Z + 8'd1, 1'b1);
		send_text(OP_CHAR, CHAR_SPACE, 1'b0);
		send_text(OP_CHAR, CHAR_SPACE, 1'b1);
		send_text(OP_SEP, 8'hA5, 1'b1);
		send_text(OP_UNUSED, 8'h5A, 1'b0);

		// The end mark goes out once per run: pick whether a close or a period
		// sends it, then hit the other while already ended.
		first_end_by_close = 1'($urandom_range(0, 1));
		if (first_end_by_close)
			send_text(OP_CLOSE, 8'h00, 1'b0);
		send_text(OP_CHAR, CHAR_PERIOD, 1'b0);

		// Muted until the next separator: letters, spaces and periods drop.
		send_text(OP_CHAR, 8'h6B, 1'b0);
		send_text(OP_CHAR, CHAR_SPACE, 1'b0);
		send_text(OP_CHAR, CHAR_PERIOD, 1'b1);
		send_text(OP_SEP, 8'h00, 1'b0);

		// Letters after the end still encode; a repeated period only mutes.
		send_text(OP_CHAR, 8'h6F, 1'b0);
		send_text(OP_CHAR, CHAR_PERIOD, 1'b0);
		send_text(OP_CLOSE, 8'hFF, 1'b1);
		send_text(OP_CHAR, 8'h78, 1'b0);
		if (!first_end_by_close)
			send_text(OP_CLOSE, 8'h00, 1'b0);

		// Random part over three idle profiles.
		fill_random(ITEM_TARGET / 3);
		tx_idle_pct = 88;
		rx_idle_pct = 13;
		fill_random(2 * ITEM_TARGET / 3);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_req = 1'b1;
		fill_random(ITEM_TARGET);
		text.valid <= 1'b0;

		// Drain what is still in flight, then watch a little longer for strays.
		while (units_waiting != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d text transactions under three idle profiles and one long output hold,",
			items_sent);
		$display("with %0d timing units compared against the prediction.", units_checked);
		if (fails == 0 && units_waiting == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* sim.f */
src/mte_pkg.sv
src/mte_if.sv
src/mte_run_cnt.sv
src/morse_text_encoder_unit.sv
bench/morse_unit_checker.sv
bench/tb_top.sv
